// ===== design/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
`default_nettype none

package b64e_pkg;

    // Position of the next byte within its three-byte group.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH = 2;

    // One byte's worth of output characters, waiting to be sent.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            end_flag;
    } t_job;

    // Maps a six-bit code onto the standard base64 alphabet.
    function automatic logic [7:0] b64e_sym(input logic [5:0] code);
        logic [7:0] wide;
        wide = {2'b00, code};
        if (code < 6'd26) begin
            b64e_sym = 8'h41 + wide;
        end else if (code < 6'd52) begin
            b64e_sym = 8'h61 + wide - 8'd26;
        end else if (code < 6'd62) begin
            b64e_sym = 8'h30 + wide - 8'd52;
        end else if (code == 6'd62) begin
            b64e_sym = 8'h2B;
        end else begin
            b64e_sym = 8'h2F;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/base64_stream_encoder.sv =====
// Each accepted byte is queued as a job before its characters enter the output register.
// Throughput: one character per cycle while the output is not stalled, set by the single
// output register; a byte yields one, two, three or four characters, four per three bytes.
// A two-entry job queue lets the input keep taking beats while characters wait at the output.
// Reset (synchronous, active low) empties the queue and output and restarts the group.
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_char,
    output logic            o_end_of_text
);

    // The front end turns each accepted beat into one job holding all the characters
    // that byte completes, including any pad characters on the final byte.
    t_job front_job;
    t_job head_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic accept;

    // A beat is taken whenever the queue has room, regardless of the output side.
    assign o_ready = !queue_full;
    assign accept  = i_valid && o_ready;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_job        (front_job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (queue_pop),
        .o_job   (head_job)
    );

    // The back end walks through the head job a character at a time and frees
    // the queue entry when its last character moves into the output register.
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (queue_valid),
        .i_job         (head_job),
        .o_pop         (queue_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

endmodule

`default_nettype wire

// ===== design/b64e_front.sv =====
// Front end: tracks the group position and turns each accepted byte into a character job.
`default_nettype none

module b64e_front import b64e_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output t_job            o_job
);

    logic [1:0] r_pos;
    logic [3:0] r_left;
    logic [1:0] n_pos;
    logic [3:0] n_left;

    always_comb begin
        o_job.chars    = {PAD_CHAR, PAD_CHAR, 8'h00, 8'h00};
        o_job.end_flag = i_final_byte;
        unique case (r_pos)
            POS_SECOND: begin
                o_job.chars[0] = b64e_sym({r_left[1:0], i_data_byte[7:4]});
                o_job.chars[1] = b64e_sym({i_data_byte[3:0], 2'b00});
                o_job.last_idx = i_final_byte ? 2'd2 : 2'd0;
                n_pos          = POS_THIRD;
                n_left         = i_data_byte[3:0];
            end
            POS_THIRD: begin
                o_job.chars[0] = b64e_sym({r_left, i_data_byte[7:6]});
                o_job.chars[1] = b64e_sym(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
                n_pos          = POS_FIRST;
                n_left         = 4'd0;
            end
            default: begin
                // The unused position code behaves as the first byte of a group.
                o_job.chars[0] = b64e_sym(i_data_byte[7:2]);
                o_job.chars[1] = b64e_sym({i_data_byte[1:0], 4'b0000});
                o_job.last_idx = i_final_byte ? 2'd3 : 2'd0;
                n_pos          = POS_SECOND;
                n_left         = {2'b00, i_data_byte[1:0]};
            end
        endcase
        if (i_final_byte) begin
            n_pos  = POS_FIRST;
            n_left = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_FIRST;
            r_left <= 4'd0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// Two-entry job queue between the front end and the character sender.
`default_nettype none

module b64e_queue import b64e_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// Back end: sends head job characters one per cycle if unstalled, via an output register.
`default_nettype none

module b64e_back import b64e_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  t_job            i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_char,
    output logic            o_end_of_text
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_char;
    logic       r_end;
    logic       load;
    logic       is_last;

    assign load    = !r_valid || i_ready;
    assign is_last = (r_idx == i_job.last_idx);
    assign o_pop   = load && i_job_valid && is_last;

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_end_of_text = r_end;

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_char <= i_job.chars[r_idx];
            r_end  <= i_job.end_flag && is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/b64e_checker.sv =====
// Port-level checker for the base64 stream encoder, bound to the top level.
`default_nettype none

module b64e_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_out_char,
    input wire logic       o_end_of_text
);

    // Nothing is shown on the output the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A stalled output beat holds its character.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char) && $stable(o_end_of_text))
        else $error("stalled output beat changed");

    // Every character is from the base64 alphabet or the pad.
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_char >= 8'h41 && o_out_char <= 8'h5A)
                 || (o_out_char >= 8'h61 && o_out_char <= 8'h7A)
                 || (o_out_char >= 8'h30 && o_out_char <= 8'h39)
                 || o_out_char == 8'h2B || o_out_char == 8'h2F || o_out_char == 8'h3D)
        else $error("character outside the base64 alphabet");

    // A pad that does not end the text is followed at once by the closing pad.
    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_out_char == 8'h3D && !o_end_of_text
        |=> o_valid && o_out_char == 8'h3D && o_end_of_text)
        else $error("first pad not followed by the closing pad");

    // An accepted input beat is always followed by a character on show.
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 o_valid)
        else $error("accepted beat produced no output character");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_char    (o_out_char),
    .o_end_of_text (o_end_of_text)
);

`default_nettype wire

// ===== dv/tb_base64_stream_encoder.sv =====
// Self-checking testbench for the base64 stream encoder: directed table, random messages.
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
    import b64e_pkg::*;

    // A phase with no beat on either side for this many cycles means the block has hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected character, so that a stray extra one is caught.
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 105;

    // Standard alphabet, character 0 in the top byte so that index 0 is 'A'.
    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One row of the directed table. Where n_typed is non-zero the characters are given
    // by hand; otherwise the row is checked against the encoder model below.
    typedef struct {
        logic [7:0]      data;
        logic            fin;
        int              n_typed;
        logic [0:3][7:0] typed;
    } t_stim_row;

    // One character beat as it is expected on the output side.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_char_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_char;
    logic       o_end_of_text;

    // Encoder model state: where the next byte falls in its group, and the bits it inherits.
    logic [1:0] grp_pos = POS_FIRST;
    logic [3:0] carry_bits = 4'h0;

    t_char_beat expected_chars[$];
    t_char_beat next_char;
    t_stim_row  stim_table[$];

    int n_errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    base64_stream_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Encodes one byte against the model state and returns how many characters it yields.
    // The first byte of a group gives its top six bits; the second gives the two carried
    // bits and its top nibble; the third gives two characters. A final byte flushes the
    // partial character and pads with '=' to a whole quantum, then restarts the group.
    function automatic int base64_encode_byte(input logic [7:0] b, input logic fin,
                                              output logic [0:3][7:0] chars);
        int n;
        n = 0;
        chars = '0;
        case (grp_pos)
            POS_SECOND: begin
                chars[0] = B64_ALPHABET[{carry_bits[1:0], b[7:4]}];
                n = 1;
                if (fin) begin
                    chars[1] = B64_ALPHABET[{b[3:0], 2'b00}];
                    chars[2] = PAD_CHAR;
                    n = 3;
                end
                grp_pos = POS_THIRD;
                carry_bits = b[3:0];
            end
            POS_THIRD: begin
                chars[0] = B64_ALPHABET[{carry_bits, b[7:6]}];
                chars[1] = B64_ALPHABET[b[5:0]];
                n = 2;
                grp_pos = POS_FIRST;
                carry_bits = 4'h0;
            end
            default: begin
                // The unused position value behaves as the start of a group.
                chars[0] = B64_ALPHABET[b[7:2]];
                n = 1;
                if (fin) begin
                    chars[1] = B64_ALPHABET[{b[1:0], 4'b0000}];
                    chars[2] = PAD_CHAR;
                    chars[3] = PAD_CHAR;
                    n = 4;
                end
                grp_pos = POS_SECOND;
                carry_bits = {2'b00, b[1:0]};
            end
        endcase
        if (fin) begin
            grp_pos = POS_FIRST;
            carry_bits = 4'h0;
        end
        return n;
    endfunction

    task automatic add_row(input logic [7:0] data, input logic fin, input int n_typed,
                           input logic [0:3][7:0] typed);
        t_stim_row row;
        row.data = data;
        row.fin = fin;
        row.n_typed = n_typed;
        row.typed = typed;
        stim_table.push_back(row);
    endtask

    // Offers one byte beat, with random idle cycles ahead of it, and files the characters
    // it should produce once the beat has been taken. Valid is left high afterwards so
    // that back-to-back beats are offered without a gap.
    task automatic send_beat(input logic [7:0] b, input logic fin, input int n_typed,
                             input logic [0:3][7:0] typed);
        logic [0:3][7:0] chars;
        int              n;
        t_char_beat      beat;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_ready);
        n = base64_encode_byte(b, fin, chars);
        // Hand-typed rows override the model, but the model state still moves on.
        if (n_typed > 0) begin
            chars = typed;
            n = n_typed;
        end
        for (int k = 0; k < n; k++) begin
            beat.ch = chars[k];
            beat.eot = fin && (k == n - 1);
            expected_chars.push_back(beat);
        end
    endtask

    // Lowers valid and holds off until every expected character has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Random messages: mostly short, now and then long, with the end mark on the last
    // byte. All-zero and all-one bytes are favoured so that the alphabet ends are hit.
    task automatic send_random_phase(input int n_items);
        int         sent;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_beat(b, k == len - 1, 0, '0);
            end
            sent += len;
        end
    endtask

    // Receiver: stalls at random, and checks every character beat it takes against the
    // oldest expectation, field by field.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character beat, expected none, got char %h eot %b",
                         $time, o_out_char, o_end_of_text);
                n_errors = n_errors + 1;
            end else begin
                next_char = expected_chars.pop_front();
                if (o_out_char !== next_char.ch) begin
                    $display("%0t: out_char mismatch, expected %h, got %h",
                             $time, next_char.ch, o_out_char);
                    n_errors = n_errors + 1;
                end
                if (o_end_of_text !== next_char.eot) begin
                    $display("%0t: end_of_text mismatch, expected %b, got %b",
                             $time, next_char.eot, o_end_of_text);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // Watchdog: any beat on either side, or reset, counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed table. Classic vectors are typed in; the rest go through the model.
        // A lone byte, at both ends of the range, gives two characters and two pads.
        add_row(8'h00, 1'b1, 4, "AA==");
        add_row(8'hFF, 1'b1, 4, "/w==");
        // Two bytes: one pad.
        add_row(8'h4D, 1'b0, 1, "T   ");
        add_row(8'h61, 1'b1, 3, "WE= ");
        // A whole group ending the message: no pads, end mark on the fourth character.
        add_row(8'h4D, 1'b0, 1, "T   ");
        add_row(8'h61, 1'b0, 1, "W   ");
        add_row(8'h6E, 1'b1, 2, "Fu  ");
        // All ones across a group that does not end the message, then all zeros.
        add_row(8'hFF, 1'b0, 1, "/   ");
        add_row(8'hFF, 1'b0, 1, "/   ");
        add_row(8'hFF, 1'b0, 2, "//  ");
        add_row(8'h00, 1'b0, 1, "A   ");
        add_row(8'h00, 1'b0, 1, "A   ");
        add_row(8'h00, 1'b1, 2, "AA  ");
        // Single-bit and alternating patterns; a final byte in the first and in the second
        // group position, and a new message straight after a final byte.
        add_row(8'h80, 1'b0, 0, '0);
        add_row(8'h01, 1'b1, 0, '0);
        add_row(8'h7F, 1'b1, 0, '0);
        add_row(8'h55, 1'b0, 0, '0);
        add_row(8'hAA, 1'b0, 0, '0);
        add_row(8'h0F, 1'b0, 0, '0);
        add_row(8'hF0, 1'b1, 0, '0);
        add_row(8'hC3, 1'b0, 0, '0);
        add_row(8'h3C, 1'b1, 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[r]) begin
            send_beat(stim_table[r].data, stim_table[r].fin, stim_table[r].n_typed,
                      stim_table[r].typed);
        end
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalling, then both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            send_random_phase(ITEMS_PER_PHASE);
            wait_drained();
        end

        // Everything has come out; give the block time to show any stray extra character.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
